### rtl/core/tmrc_pkg.sv
// Shared constants, types and helper functions for the machine-code relabel filter.
package tmrc_pkg;

  localparam int unsigned CODE_W      = 44;
  localparam int unsigned DIGIT_W     = 5;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned NUM_STATES  = 5;
  localparam int unsigned RADIX       = 20;
  localparam int unsigned NUM_PERMS   = 24;
  localparam int unsigned MULT_W      = 5;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CODE_W-1:0] CODE_LIMIT = 44'd10240000000000;

  // relabelings of states 1..4: nibbles give new labels of states 1,2,3,4
  localparam logic [15:0] PERM_TAB [NUM_PERMS] = '{
    16'h1234, 16'h1243, 16'h1324, 16'h1342, 16'h1423, 16'h1432,
    16'h2134, 16'h2143, 16'h2314, 16'h2341, 16'h2413, 16'h2431,
    16'h3124, 16'h3142, 16'h3214, 16'h3241, 16'h3412, 16'h3421,
    16'h4123, 16'h4132, 16'h4213, 16'h4231, 16'h4312, 16'h4321
  };

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] dig;
    logic [CODE_W-1:0]  rem;
  } split_t;

  typedef struct packed {
    logic    vld;
    logic    oor;
    digits_t dig;
  } digs_t;

  typedef struct packed {
    logic                 vld;
    logic                 oor;
    logic [NUM_PERMS-1:0] fix;
    logic [NUM_PERMS-1:0] less;
  } cmp_t;

  // j * 20^k
  function automatic logic [CODE_W-1:0] digit_weight(int unsigned k, int unsigned j);
    logic [63:0] w;
    w = 64'(j);
    for (int unsigned i = 0; i < NUM_DIGITS; i++) begin
      if (i < k) begin
        w = w * 64'(RADIX);
      end
    end
    return w[CODE_W-1:0];
  endfunction

  // one base-20 digit at weight 20^k: parallel trial subtracts, largest fit wins
  function automatic split_t split_digit(logic [CODE_W-1:0] x, int unsigned k);
    split_t      r;
    logic [CODE_W:0] diff;
    r.dig = '0;
    r.rem = x;
    for (int unsigned j = 1; j < RADIX; j++) begin
      diff = {1'b0, x} - {1'b0, digit_weight(k, j)};
      if (!diff[CODE_W]) begin
        r.dig = DIGIT_W'(j);
        r.rem = diff[CODE_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] perm_map(logic [15:0] w, logic [2:0] s);
    logic [2:0] r;
    case (s)
      3'd1:    r = w[14:12];
      3'd2:    r = w[10:8];
      3'd3:    r = w[6:4];
      3'd4:    r = w[2:0];
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic digits_t relabel(digits_t dig, logic [15:0] w);
    digits_t            od;
    logic [DIGIT_W-1:0] d;
    logic [2:0]         ns;
    logic [2:0]         ps;
    logic [3:0]         pos;
    od = '0;
    for (int unsigned s = 0; s < NUM_STATES; s++) begin
      for (int unsigned t = 0; t < 2; t++) begin
        d   = dig[2*s+t];
        ns  = perm_map(w, d[4:2]);
        ps  = perm_map(w, 3'(s));
        pos = {ps, 1'b0} + 4'(t);
        od[pos] = {ns, d[1:0]};
      end
    end
    return od;
  endfunction

  function automatic logic [MULT_W-1:0] mult_of(logic [MULT_W-1:0] cnt);
    logic [MULT_W-1:0] r;
    case (cnt)
      5'd1:    r = 5'd24;
      5'd2:    r = 5'd12;
      5'd3:    r = 5'd8;
      5'd4:    r = 5'd6;
      5'd6:    r = 5'd4;
      5'd8:    r = 5'd3;
      5'd12:   r = 5'd2;
      5'd24:   r = 5'd1;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/turing_machine_state_relabel_canon_core.sv
// Top level of the 5-state 2-symbol machine-code relabel filter.
//
// Slave stream: one machine code per item in s_axis_tdata_i[43:0]
// (ten base-20 digits, state 0 in the lowest pair). Master stream: one
// result per item, multiplicity in tdata[4:0] and canonical flag in tdata[5].
// Codes at or above 20^10 give multiplicity 0 and flag 0.
// Path from acceptance to the result showing on the master
// side: thirteen register stages, the first loaded at the accepting edge:
// ten digit stages (one base-20 digit each, parallel trial subtracts),
// one relabel-and-compare stage over all 24 relabelings, one count stage
// and the output register. Throughput: one item per cycle while not stalled.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_axis_tready_o drops; nothing is lost or repeated, and bubbles
// ahead of a held result are not squeezed out. Reset clears all valid
// bits; no clearing pass, items are taken from the first cycle after it.
module turing_machine_state_relabel_canon_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [tmrc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // [43:0] machine_code
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [tmrc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o   // [4:0] multiplicity, [5] is_canonical
);

  logic                        adv;
  tmrc_pkg::digs_t             digs;
  tmrc_pkg::cmp_t              cmp;
  logic                        res_vld;
  logic [tmrc_pkg::MULT_W-1:0] mult;
  logic                        canon;

  assign adv             = !res_vld || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  tmrc_digit_split u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_axis_tvalid_i),
    .code_i (s_axis_tdata_i[tmrc_pkg::CODE_W-1:0]),
    .out_o  (digs)
  );

  tmrc_relabel u_relabel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (digs),
    .out_o  (cmp)
  );

  tmrc_tally u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .in_i    (cmp),
    .vld_o   (res_vld),
    .mult_o  (mult),
    .canon_o (canon)
  );

  assign m_axis_tvalid_o = res_vld;
  assign m_axis_tdata_o  = {2'b00, canon, mult};

endmodule

### rtl/core/tmrc_digit_split.sv
// Ten-stage pipeline splitting the code into base-20 digits, most significant first.
module tmrc_digit_split (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         vld_i,
  input  logic [tmrc_pkg::CODE_W-1:0]  code_i,
  output tmrc_pkg::digs_t              out_o
);

  logic [tmrc_pkg::NUM_DIGITS-1:0] vld_q;
  logic [tmrc_pkg::NUM_DIGITS-1:0] oor_q;
  logic [tmrc_pkg::CODE_W-1:0]     rem_q [tmrc_pkg::NUM_DIGITS-1];
  tmrc_pkg::digits_t               dig_q [tmrc_pkg::NUM_DIGITS];
  tmrc_pkg::digits_t               dig_d [tmrc_pkg::NUM_DIGITS];
  tmrc_pkg::split_t                split_d [tmrc_pkg::NUM_DIGITS];

  always_comb begin
    split_d[0] = tmrc_pkg::split_digit(code_i, tmrc_pkg::NUM_DIGITS - 1);
    for (int unsigned s = 1; s < tmrc_pkg::NUM_DIGITS; s++) begin
      split_d[s] = tmrc_pkg::split_digit(rem_q[s-1], tmrc_pkg::NUM_DIGITS - 1 - s);
    end
  end

  always_comb begin
    dig_d[0] = '0;
    dig_d[0][tmrc_pkg::NUM_DIGITS-1] = split_d[0].dig;
    for (int unsigned s = 1; s < tmrc_pkg::NUM_DIGITS; s++) begin
      dig_d[s] = dig_q[s-1];
      dig_d[s][tmrc_pkg::NUM_DIGITS-1-s] = split_d[s].dig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[tmrc_pkg::NUM_DIGITS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      oor_q[0] <= (code_i >= tmrc_pkg::CODE_LIMIT);
      rem_q[0] <= split_d[0].rem;
      dig_q[0] <= dig_d[0];
      for (int unsigned s = 1; s < tmrc_pkg::NUM_DIGITS; s++) begin
        oor_q[s] <= oor_q[s-1];
        dig_q[s] <= dig_d[s];
      end
      for (int unsigned s = 1; s < tmrc_pkg::NUM_DIGITS - 1; s++) begin
        rem_q[s] <= split_d[s].rem;
      end
    end
  end

  assign out_o.vld = vld_q[tmrc_pkg::NUM_DIGITS-1];
  assign out_o.oor = oor_q[tmrc_pkg::NUM_DIGITS-1];
  assign out_o.dig = dig_q[tmrc_pkg::NUM_DIGITS-1];

endmodule

### rtl/core/tmrc_relabel.sv
// Relabel stage: applies all 24 relabelings and compares each against the code.
module tmrc_relabel (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  tmrc_pkg::digs_t in_i,
  output tmrc_pkg::cmp_t  out_o
);

  logic [tmrc_pkg::NUM_PERMS-1:0] fix_d;
  logic [tmrc_pkg::NUM_PERMS-1:0] less_d;
  tmrc_pkg::digits_t              od [tmrc_pkg::NUM_PERMS];
  logic                           vld_q;
  logic                           oor_q;
  logic [tmrc_pkg::NUM_PERMS-1:0] fix_q;
  logic [tmrc_pkg::NUM_PERMS-1:0] less_q;

  // digits are < 20 in 5 bits, so packed compare matches base-20 order
  always_comb begin
    for (int unsigned p = 0; p < tmrc_pkg::NUM_PERMS; p++) begin
      od[p]     = tmrc_pkg::relabel(in_i.dig, tmrc_pkg::PERM_TAB[p]);
      fix_d[p]  = (od[p] == in_i.dig);
      less_d[p] = (od[p] < in_i.dig);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      oor_q  <= in_i.oor;
      fix_q  <= fix_d;
      less_q <= less_d;
    end
  end

  assign out_o.vld  = vld_q;
  assign out_o.oor  = oor_q;
  assign out_o.fix  = fix_q;
  assign out_o.less = less_q;

endmodule

### rtl/core/tmrc_tally.sv
// Tally stages: counts fixing relabelings, then forms multiplicity and canonical flag.
module tmrc_tally (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  tmrc_pkg::cmp_t                in_i,
  output logic                          vld_o,
  output logic [tmrc_pkg::MULT_W-1:0]   mult_o,
  output logic                          canon_o
);

  logic                        cnt_vld_q;
  logic                        cnt_oor_q;
  logic [tmrc_pkg::MULT_W-1:0] cnt_q;
  logic                        cnt_canon_q;
  logic                        res_vld_q;
  logic [tmrc_pkg::MULT_W-1:0] mult_q;
  logic                        canon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (adv_i) begin
      cnt_vld_q <= in_i.vld;
      res_vld_q <= cnt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cnt_oor_q   <= in_i.oor;
      cnt_q       <= tmrc_pkg::MULT_W'($countones(in_i.fix));
      cnt_canon_q <= ~|in_i.less;
      mult_q      <= cnt_oor_q ? '0 : tmrc_pkg::mult_of(cnt_q);
      canon_q     <= cnt_canon_q & ~cnt_oor_q;
    end
  end

  assign vld_o   = res_vld_q;
  assign mult_o  = mult_q;
  assign canon_o = canon_q;

endmodule

### rtl/core/tmrc_checker.sv
// Port-level checks for the relabel filter, bound to the top level.
module tmrc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [tmrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [tmrc_pkg::MULT_W-1:0] mult;
  assign mult = m_axis_tdata_o[tmrc_pkg::MULT_W-1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input refused with no result held");

  a_mult_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (mult == 5'd0 || mult == 5'd1 || mult == 5'd2 || mult == 5'd3 ||
                         mult == 5'd4 || mult == 5'd6 || mult == 5'd8 || mult == 5'd12 ||
                         mult == 5'd24))
    else $error("multiplicity not a divisor of 24");

  a_oor_not_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (mult == 5'd0) |-> !m_axis_tdata_o[5] && (m_axis_tdata_o[7:6] == 2'b00))
    else $error("out-of-range code flagged canonical");

endmodule

bind turing_machine_state_relabel_canon_core tmrc_checker u_tmrc_checker (.*);

### bench/turing_machine_state_relabel_canon_core_test.sv
`timescale 1ns / 1ps
// Stream testbench for the machine-code relabel filter: random and directed codes, own predictor.
module turing_machine_state_relabel_canon_core_test;

  localparam int unsigned CODE_W     = tmrc_pkg::CODE_W;
  localparam int unsigned RANDOM_CNT = 900;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned DRAIN      = 30;

  typedef logic [4:0] digit_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic       is_canonical;
    logic [4:0] multiplicity;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [tmrc_pkg::IN_TDATA_W-1:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [tmrc_pkg::OUT_TDATA_W-1:0] m_data;

  code_t    codes_to_send[$];
  verdict_t expected_verdicts[$];

  int unsigned codes_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned out_of_range_seen = 0;
  int unsigned canonical_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic [24:0] mult_seen = '0;
  bit calm = 1'b0;

  turing_machine_state_relabel_canon_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // multiplicity and canonical flag over all relabelings of states 1..4
  function automatic verdict_t classify_code(code_t code);
    digit_t      dig[10];
    digit_t      moved[10];
    logic [2:0]  lab[5];
    logic [63:0] rest;
    logic [63:0] img;
    digit_t      dg;
    int unsigned fixes;
    bit          canon;
    verdict_t    v;
    v = '0;
    if (code >= tmrc_pkg::CODE_LIMIT) return v;
    rest = 64'(code);
    for (int i = 0; i < 10; i++) begin
      dig[i] = digit_t'(rest % 20);
      rest = rest / 20;
    end
    fixes = 0;
    canon = 1'b1;
    lab[0] = 3'd0;
    for (int a = 1; a <= 4; a++) begin
      for (int b = 1; b <= 4; b++) begin
        for (int c = 1; c <= 4; c++) begin
          if (b != a && c != a && c != b) begin
            lab[1] = 3'(a);
            lab[2] = 3'(b);
            lab[3] = 3'(c);
            lab[4] = 3'(10 - a - b - c);
            for (int s = 0; s < 5; s++) begin
              for (int t = 0; t < 2; t++) begin
                dg = dig[2*s+t];
                moved[2*lab[s]+t] = {lab[dg[4:2]], dg[1:0]};
              end
            end
            img = '0;
            for (int i = 9; i >= 0; i--) img = img * 20 + 64'(moved[i]);
            if (img == 64'(code)) fixes++;
            if (img < 64'(code)) canon = 1'b0;
          end
        end
      end
    end
    v.multiplicity = 5'(24 / fixes);
    v.is_canonical = canon;
    return v;
  endfunction

  function automatic code_t pack_digits(digit_t dig[10]);
    logic [63:0] acc;
    acc = '0;
    for (int i = 9; i >= 0; i--) acc = acc * 20 + 64'(dig[i]);
    return code_t'(acc);
  endfunction

  // random code left unchanged by the relabeling g (g[0] is always 0)
  function automatic code_t code_fixed_by(logic [2:0] g[5], bit plain);
    int unsigned cyc[5];
    bit          done[5];
    digit_t      dig[10];
    logic [2:0]  cur;
    logic [2:0]  ns;
    logic [1:0]  low;
    for (int s = 0; s < 5; s++) begin
      cur = g[s];
      cyc[s] = 1;
      while (cur != 3'(s)) begin
        cur = g[cur];
        cyc[s]++;
      end
      done[s] = 1'b0;
    end
    for (int s = 0; s < 5; s++) begin
      if (!done[s]) begin
        for (int t = 0; t < 2; t++) begin
          ns = 3'($urandom_range(0, 4));
          if (cyc[s] % cyc[ns] != 0) ns = 3'd0;
          low = plain ? 2'd0 : 2'($urandom_range(0, 3));
          cur = 3'(s);
          for (int k = 0; k < cyc[s]; k++) begin
            dig[2*cur+t] = {ns, low};
            done[cur] = 1'b1;
            ns = g[ns];
            cur = g[cur];
          end
        end
      end
    end
    return pack_digits(dig);
  endfunction

  function automatic code_t random_symmetric_code();
    logic [2:0] g[5];
    logic [2:0] tmp;
    int unsigned j;
    for (int s = 0; s < 5; s++) g[s] = 3'(s);
    for (int s = 4; s > 1; s--) begin
      j = $urandom_range(1, s);
      tmp = g[s];
      g[s] = g[j];
      g[j] = tmp;
    end
    return code_fixed_by(g, $urandom_range(0, 2) == 0);
  endfunction

  function automatic code_t random_code();
    digit_t      dig[10];
    int unsigned r;
    logic [63:0] wide;
    r = $urandom_range(0, 99);
    if (r < 45) return random_symmetric_code();
    if (r < 65) begin
      wide = {$urandom, $urandom};
      return code_t'(wide % 64'(tmrc_pkg::CODE_LIMIT));
    end
    if (r < 75) begin
      // digits from the ends of the range: next state 0 or next state 4
      for (int i = 0; i < 10; i++)
        dig[i] = digit_t'($urandom_range(0, 1) ? $urandom_range(16, 19) : $urandom_range(0, 3));
      return pack_digits(dig);
    end
    if (r < 80) return tmrc_pkg::CODE_LIMIT + code_t'($urandom_range(0, 3)) - code_t'(2);
    return code_t'({$urandom, $urandom});
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void queue_code(code_t code);
    codes_to_send.insert(codes_to_send.size(), code);
  endfunction

  // driver: presents pending codes, records the verdict of each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      gap_left = 0;
    end else begin
      if (s_valid && s_ready) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 classify_code(s_data[CODE_W-1:0]));
        codes_taken++;
        calm = ((codes_taken >> 7) & 3) == 3;
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0 || codes_to_send.size() == 0) begin
          s_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          s_valid <= 1'b1;
          s_data <= {{(tmrc_pkg::IN_TDATA_W - CODE_W){1'b0}}, codes_to_send.pop_front()};
          gap_left = draw_wait();
        end
      end
    end
  end

  // monitor: checks each result item against the oldest recorded verdict
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result item with none expected, actual %h", $time, m_data);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_seen++;
          if (m_data[4:0] != want.multiplicity) begin
            $display("%0t: multiplicity expected %0d actual %0d", $time,
                     want.multiplicity, m_data[4:0]);
            mismatches++;
          end
          if (m_data[5] != want.is_canonical) begin
            $display("%0t: is_canonical expected %0d actual %0d", $time,
                     want.is_canonical, m_data[5]);
            mismatches++;
          end
          if (want.multiplicity == 0) out_of_range_seen++;
          if (want.is_canonical) canonical_seen++;
          mult_seen[want.multiplicity] = 1'b1;
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        m_ready <= 1'b0;
        stall_left--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    digit_t     dig[10];
    logic [2:0] g[5];
    queue_code('0);
    queue_code(code_t'(1));
    queue_code(tmrc_pkg::CODE_LIMIT - code_t'(1));
    queue_code(tmrc_pkg::CODE_LIMIT);
    queue_code(tmrc_pkg::CODE_LIMIT + code_t'(1));
    queue_code('1);
    queue_code(code_t'(64'd512000000000));
    for (int i = 0; i < 10; i++) dig[i] = digit_t'(16);
    queue_code(pack_digits(dig));
    for (int i = 0; i < 10; i++) dig[i] = digit_t'(i % 2 ? 3 : 1);
    queue_code(pack_digits(dig));
    for (int i = 0; i < 10; i++) dig[i] = digit_t'(19 - i);
    queue_code(pack_digits(dig));
    // one relabeling of each permutation shape: swap, double swap, rotation of three states, rotation of four states
    g = '{3'd0, 3'd2, 3'd1, 3'd3, 3'd4};
    queue_code(code_fixed_by(g, 1'b0));
    queue_code(code_fixed_by(g, 1'b1));
    g = '{3'd0, 3'd2, 3'd1, 3'd4, 3'd3};
    queue_code(code_fixed_by(g, 1'b0));
    queue_code(code_fixed_by(g, 1'b1));
    g = '{3'd0, 3'd2, 3'd3, 3'd1, 3'd4};
    queue_code(code_fixed_by(g, 1'b0));
    queue_code(code_fixed_by(g, 1'b1));
    g = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd1};
    queue_code(code_fixed_by(g, 1'b0));
    queue_code(code_fixed_by(g, 1'b1));
    for (int i = 0; i < RANDOM_CNT; i++) queue_code(random_code());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (codes_to_send.size() != 0 || s_valid || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("%0d codes sent, %0d results checked: %0d out of range, %0d canonical",
             codes_taken, verdicts_seen, out_of_range_seen, canonical_seen);
    $display("multiplicities seen (bit per value): %b", mult_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
